>>> rtl/ffba_pkg.sv
// ============================================================================
// First-fit allocator package
// Shared widths, status codes and state encoding for the block allocator.
// ============================================================================
`default_nettype none
package ffba_pkg;
  localparam int unsigned MaxBlocksDefault = 64;
  localparam int unsigned PoolAddrBitsDefault = 16;
  localparam int unsigned SizeW = 17;
  localparam int unsigned AddrW = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StBadParam  = 3'd1;
  localparam logic [StatusW-1:0] StNoMem     = 3'd2;
  localparam logic [StatusW-1:0] StTableFull = 3'd3;
  localparam logic [StatusW-1:0] StNotSetUp  = 3'd4;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SPLIT_WR,
    S_NB_RD,
    S_NB_CHK,
    S_SHDN_RD,
    S_SHDN_WR,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

>>> rtl/first_fit_block_allocator_top.sv
// ============================================================================
// First-fit block allocator
// Keeps an ordered table of pool blocks in one RAM; allocates first fit,
// frees with coalescing of free neighbors.
// ============================================================================
//  channel   | direction | handshake
//  request   | in        | start while busy low
//  result    | out       | done_o strobe, one cycle, cannot be held off
//  pool size | in        | cfg_valid_i and cfg_ready_o
//
// Each scanned entry takes a read state and a check state, and each shifted
// entry a read state and a write state, since the single RAM port allows one
// read or one write per cycle. A free can add up to two downward shifts of the
// tail. Reset and pool size writes set entry 0 in registers; later entries
// are only read once written. The result cannot be stalled.
`default_nettype none
module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS     = ffba_pkg::MaxBlocksDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind_i,
  input  wire logic [ffba_pkg::SizeW-1:0]    size_i,
  input  wire logic [ffba_pkg::AddrW-1:0]    address_i,
  output logic                               done_o,
  output logic      [ffba_pkg::StatusW-1:0]  status_o,
  output logic      [ffba_pkg::AddrW-1:0]    block_address_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ffba_pkg::SizeW-1:0]    cfg_data_i
);
  localparam int unsigned PoolAddrBits = ffba_pkg::PoolAddrBitsDefault;
  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EntW = ffba_pkg::AddrW + ffba_pkg::SizeW + 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);
  localparam logic [ffba_pkg::SizeW:0] PoolCap = (ffba_pkg::SizeW+1)'(64'd1 << PoolAddrBits);

  typedef struct packed {
    logic [ffba_pkg::AddrW-1:0] offset;
    logic [ffba_pkg::SizeW-1:0] size;
    logic                       free;
  } entry_t;

  ffba_pkg::state_e state_q, state_d;
  logic [ffba_pkg::SizeW-1:0] pool_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] k_q, k_d;     // matched index
  logic [CntW-1:0] j_q, j_d;     // shift pointer
  logic kind_q;
  logic [ffba_pkg::SizeW-1:0] req_q;
  logic [ffba_pkg::AddrW-1:0] addr_q;
  entry_t cur_q, cur_d;          // entry at k
  logic [1:0] phase_q, phase_d;  // free: 0 successor, 1 predecessor, 2/3 merge shift
  logic [ffba_pkg::StatusW-1:0] st_q, st_d;
  logic [ffba_pkg::AddrW-1:0] res_q, res_d;
  logic       we;
  logic [IdxW-1:0] ra;
  entry_t wd, rd, rdm;
  entry_t e0_q, e0_d;            // entry 0 shadow, reset on init
  logic   e0_hit_q, e0_hit_d;
  logic [ffba_pkg::SizeW:0] sum;
  logic [ffba_pkg::SizeW-1:0] cfg_sat;

  ffba_ram #(.Width(EntW), .Depth(MAX_BLOCKS)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ra), .wdata_i(wd), .rdata_o(rd)
  );

  // Entry 0 lives in registers so reset and pool writes need no RAM sweep.
  assign rdm = e0_hit_q ? e0_q : rd;
  assign cfg_sat = ({1'b0, cfg_data_i} > PoolCap) ? ffba_pkg::SizeW'(PoolCap) : cfg_data_i;
  assign busy = (state_q != ffba_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == ffba_pkg::S_IDLE) && !start;
  assign done_o = (state_q == ffba_pkg::S_DONE);
  assign status_o = st_q;
  assign block_address_o = res_q;
  assign sum = {1'b0, cur_q.size} + {1'b0, rdm.size};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_IDLE;
      pool_q <= ffba_pkg::SizeW'(PoolCap);
      cnt_q <= CntW'(1);
      e0_q <= '{offset: '0, size: ffba_pkg::SizeW'(PoolCap), free: 1'b1};
      e0_hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      e0_q <= e0_d;
      e0_hit_q <= e0_hit_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pool_q <= cfg_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; j_q <= j_d; cur_q <= cur_d;
    phase_q <= phase_d; st_q <= st_d; res_q <= res_d;
    if (start && !busy) begin
      kind_q <= kind_i; req_q <= size_i; addr_q <= address_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; k_d = k_q; j_d = j_q; cur_d = cur_q;
    phase_d = phase_q; st_d = st_q; res_d = res_q; e0_d = e0_q;
    we = 1'b0; ra = '0; wd = '0; e0_hit_d = 1'b0;
    unique case (state_q)
      ffba_pkg::S_IDLE: begin
        if (start) begin
          res_d = '0; k_d = '0;
          if (pool_q == '0) begin
            st_d = ffba_pkg::StNotSetUp; state_d = ffba_pkg::S_DONE;
          end else if (kind_i == ffba_pkg::KindAlloc && size_i == '0) begin
            st_d = ffba_pkg::StBadParam; state_d = ffba_pkg::S_DONE;
          end else begin
            state_d = ffba_pkg::S_SCAN_RD;
          end
        end
      end
      ffba_pkg::S_SCAN_RD: begin
        if (k_q >= cnt_q) begin
          st_d = kind_q ? ffba_pkg::StBadParam : ffba_pkg::StNoMem;
          state_d = ffba_pkg::S_DONE;
        end else begin
          ra = k_q[IdxW-1:0]; e0_hit_d = (k_q == '0);
          state_d = ffba_pkg::S_SCAN_CHK;
        end
      end
      ffba_pkg::S_SCAN_CHK: begin
        cur_d = rdm;
        state_d = ffba_pkg::S_SCAN_RD; k_d = k_q + 1'b1;
        if (kind_q == ffba_pkg::KindAlloc) begin
          if (rdm.free && rdm.size >= req_q) begin
            k_d = k_q;
            if (rdm.size != req_q && cnt_q >= CntMax) begin
              st_d = ffba_pkg::StTableFull; state_d = ffba_pkg::S_DONE;
            end else if (rdm.size != req_q) begin
              j_d = cnt_q; state_d = ffba_pkg::S_SHUP_RD;
            end else begin
              state_d = ffba_pkg::S_SPLIT_WR; phase_d = 2'd1;
            end
          end
        end else if (rdm.offset == addr_q && !rdm.free) begin
          k_d = k_q; cur_d.free = 1'b1; phase_d = 2'd0;
          state_d = ffba_pkg::S_NB_RD;
        end
      end
      // Move entries j-1 -> j for j from count down to k+2.
      ffba_pkg::S_SHUP_RD: begin
        if (j_q <= k_q + 1'b1) begin
          state_d = ffba_pkg::S_SPLIT_WR; phase_d = 2'd0;
        end else begin
          ra = IdxW'(j_q - 1'b1); e0_hit_d = ((j_q - 1'b1) == '0);
          state_d = ffba_pkg::S_SHUP_WR;
        end
      end
      ffba_pkg::S_SHUP_WR: begin
        we = 1'b1; ra = j_q[IdxW-1:0]; wd = rdm;
        j_d = j_q - 1'b1; state_d = ffba_pkg::S_SHUP_RD;
      end
      ffba_pkg::S_SPLIT_WR: begin
        if (phase_q == 2'd0) begin
          we = 1'b1; ra = IdxW'(k_q + 1'b1);
          wd = '{offset: cur_q.offset + ffba_pkg::AddrW'(req_q),
                 size: cur_q.size - req_q, free: 1'b1};
          cnt_d = cnt_q + 1'b1; phase_d = 2'd1;
        end else begin
          we = 1'b1; ra = k_q[IdxW-1:0];
          wd = '{offset: cur_q.offset, size: req_q, free: 1'b0};
          if (k_q == '0) e0_d = wd;
          st_d = ffba_pkg::StOk; res_d = cur_q.offset;
          state_d = ffba_pkg::S_DONE;
        end
      end
      // Free: phase 0 checks successor of k, phase 1 predecessor.
      ffba_pkg::S_NB_RD: begin
        if (phase_q == 2'd0 && k_q + 1'b1 < cnt_q) begin
          ra = IdxW'(k_q + 1'b1); state_d = ffba_pkg::S_NB_CHK;
        end else if (phase_q == 2'd0) begin
          phase_d = 2'd1;
        end else if (phase_q == 2'd1 && k_q != '0) begin
          ra = IdxW'(k_q - 1'b1); e0_hit_d = ((k_q - 1'b1) == '0);
          state_d = ffba_pkg::S_NB_CHK;
        end else begin
          we = 1'b1; ra = k_q[IdxW-1:0]; wd = cur_q;
          if (k_q == '0) e0_d = cur_q;
          st_d = ffba_pkg::StOk; state_d = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_NB_CHK: begin
        if (rdm.free && phase_q == 2'd0) begin
          cur_d.size = sum[ffba_pkg::SizeW-1:0];
          j_d = k_q + 2'd2; phase_d = 2'd2; state_d = ffba_pkg::S_SHDN_RD;
        end else if (rdm.free) begin
          cur_d = '{offset: rdm.offset, size: sum[ffba_pkg::SizeW-1:0], free: 1'b1};
          k_d = k_q - 1'b1; j_d = k_q + 1'b1; phase_d = 2'd3;
          state_d = ffba_pkg::S_SHDN_RD;
        end else begin
          phase_d = phase_q + 1'b1; state_d = ffba_pkg::S_NB_RD;
        end
      end
      // Move entries j -> j-1 for j up to count-1, then drop one entry.
      ffba_pkg::S_SHDN_RD: begin
        if (j_q >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          phase_d = (phase_q == 2'd2) ? 2'd1 : 2'd3;
          state_d = ffba_pkg::S_NB_RD;
        end else begin
          ra = j_q[IdxW-1:0]; state_d = ffba_pkg::S_SHDN_WR;
        end
      end
      ffba_pkg::S_SHDN_WR: begin
        we = 1'b1; ra = IdxW'(j_q - 1'b1); wd = rdm;
        j_d = j_q + 1'b1; state_d = ffba_pkg::S_SHDN_RD;
      end
      ffba_pkg::S_DONE: state_d = ffba_pkg::S_IDLE;
      default: state_d = ffba_pkg::S_IDLE;
    endcase
    // Predecessor merge done: phase 3 finishes with a write of cur at k.
    if (state_q == ffba_pkg::S_NB_RD && phase_q == 2'd3) begin
      we = 1'b1; ra = k_q[IdxW-1:0]; wd = cur_q;
      if (k_q == '0) e0_d = cur_q;
      st_d = ffba_pkg::StOk; state_d = ffba_pkg::S_DONE; e0_hit_d = 1'b0;
    end
    // A pool size write leaves one free block covering the whole pool.
    if (cfg_valid_i && cfg_ready_o) begin
      cnt_d = CntW'(1);
      e0_d = '{offset: '0, size: cfg_sat, free: 1'b1};
    end
  end
endmodule
`default_nettype wire

>>> rtl/ffba_ram.sv
// ============================================================================
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
`default_nettype none
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> rtl/ffba_checker.sv
// ============================================================================
// First-fit allocator port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
`default_nettype none
module ffba_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done_o,
  input wire logic [ffba_pkg::StatusW-1:0] status_o,
  input wire logic [ffba_pkg::AddrW-1:0]   block_address_o,
  input wire logic                         cfg_ready_o
);
  // A transfer starts a job, so the block is busy afterwards.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted request not busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ffba_pkg::StOk |-> block_address_o == '0)
    else $error("address on failure");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy) else $error("config ready while busy");
endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .status_o(status_o), .block_address_o(block_address_o), .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// First-fit block allocator testbench
// Drives directed and random bursts of allocate and free requests over several pool sizes.
// A scoreboard keeps its own block table, predicts each result and checks
// the status and block address of every result strobe in order.
// ============================================================================
`default_nettype none
module tb_top;
  localparam int unsigned NumBlocks = ffba_pkg::MaxBlocksDefault;
  localparam int unsigned PoolLimit = 1 << ffba_pkg::PoolAddrBitsDefault;
  localparam int unsigned SizeW = ffba_pkg::SizeW;
  localparam int unsigned AddrW = ffba_pkg::AddrW;
  localparam int unsigned StatusW = ffba_pkg::StatusW;

  class alloc_scoreboard;
    logic [SizeW-1:0]   pool;
    logic [AddrW-1:0]   blk_off[NumBlocks];
    logic [SizeW-1:0]   blk_size[NumBlocks];
    bit                 blk_free[NumBlocks];
    int                 blk_count;
    logic [StatusW-1:0] want_status[$];
    logic [AddrW-1:0]   want_addr[$];
    int                 errors;

    function void set_pool(logic [SizeW-1:0] v);
      pool = (v > PoolLimit) ? SizeW'(PoolLimit) : v;
      foreach (blk_off[k]) begin
        blk_off[k] = '0;
        blk_size[k] = '0;
        blk_free[k] = 1'b0;
      end
      blk_free[0] = 1'b1;
      blk_size[0] = pool;
      blk_count = 1;
    endfunction

    function void drop_entry(int idx);
      for (int k = idx; k + 1 < blk_count; k++) begin
        blk_off[k] = blk_off[k+1];
        blk_size[k] = blk_size[k+1];
        blk_free[k] = blk_free[k+1];
      end
      blk_count--;
    endfunction

    // Works out the result of one accepted request and updates the table.
    function void note_request(logic kind, logic [SizeW-1:0] req, logic [AddrW-1:0] a);
      logic [StatusW-1:0] st;
      logic [AddrW-1:0]   res;
      logic [SizeW-1:0]   rest;
      bit                 hit;
      st = ffba_pkg::StNoMem;
      res = '0;
      hit = 0;
      if (pool == 0) begin
        st = ffba_pkg::StNotSetUp;
      end else if (kind == ffba_pkg::KindAlloc) begin
        if (req == 0) st = ffba_pkg::StBadParam;
        for (int k = 0; k < blk_count && req != 0 && !hit; k++) begin
          if (blk_free[k] && blk_size[k] >= req) begin
            hit = 1;
            rest = blk_size[k] - req;
            if (rest != 0 && blk_count >= NumBlocks) begin
              st = ffba_pkg::StTableFull;
            end else begin
              if (rest != 0) begin
                for (int j = blk_count; j > k + 1; j--) begin
                  blk_off[j] = blk_off[j-1];
                  blk_size[j] = blk_size[j-1];
                  blk_free[j] = blk_free[j-1];
                end
                blk_off[k+1] = blk_off[k] + AddrW'(req);
                blk_size[k+1] = rest;
                blk_free[k+1] = 1'b1;
                blk_count++;
              end
              blk_free[k] = 1'b0;
              blk_size[k] = req;
              res = blk_off[k];
              st = ffba_pkg::StOk;
            end
          end
        end
      end else begin
        st = ffba_pkg::StBadParam;
        for (int k = 0; k < blk_count && !hit; k++) begin
          if (blk_off[k] == a && !blk_free[k]) begin
            hit = 1;
            st = ffba_pkg::StOk;
            blk_free[k] = 1'b1;
            if (k + 1 < blk_count && blk_free[k+1]) begin
              blk_size[k] += blk_size[k+1];
              drop_entry(k + 1);
            end
            if (k > 0 && blk_free[k-1]) begin
              blk_size[k-1] += blk_size[k];
              drop_entry(k);
            end
          end
        end
      end
      want_status.push_back(st);
      want_addr.push_back(res);
    endfunction

    function void check_result(logic [StatusW-1:0] st, logic [AddrW-1:0] a);
      logic [StatusW-1:0] es;
      logic [AddrW-1:0]   ea;
      if (want_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d address %0h", st, a);
      end else begin
        es = want_status.pop_front();
        ea = want_addr.pop_front();
        if (st !== es || a !== ea) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: status %0d/%0d address %0h/%0h (expected/actual)",
                     es, st, ea, a);
        end
      end
    endfunction

    function int pending();
      return want_status.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                kind_i = ffba_pkg::KindAlloc;
  logic [SizeW-1:0]    size_i = '0;
  logic [AddrW-1:0]    address_i = '0;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [AddrW-1:0]    block_address_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SizeW-1:0]    cfg_data_i = '0;

  alloc_scoreboard table_sb = new();

  first_fit_block_allocator_top dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .size_i, .address_i,
    .done_o, .status_o, .block_address_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) table_sb.check_result(status_o, block_address_o);
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send(logic kind, logic [SizeW-1:0] req, logic [AddrW-1:0] a);
    start <= 1'b1;
    kind_i <= kind;
    size_i <= req;
    address_i <= a;
    do @(posedge clk_i); while (busy);
    table_sb.note_request(kind, req, a);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (table_sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [SizeW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    table_sb.set_pool(v);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations sized to the pool and frees of
  // blocks in use, with some zero, oversized and stray requests mixed in.
  task automatic random_items(int n);
    int               left;
    int               burst;
    int               pick;
    int               idx;
    logic [SizeW-1:0] req;
    logic [AddrW-1:0] a;
    logic             kind;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && left > 0; i++) begin
        pick = $urandom_range(0, 99);
        req = '0;
        a = '0;
        kind = (pick < 55) ? ffba_pkg::KindAlloc : ffba_pkg::KindFree;
        if (kind == ffba_pkg::KindAlloc) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)
            req = SizeW'($urandom_range(1, (table_sb.pool > 64) ? table_sb.pool / 48 : 3));
          else if (pick < 85)
            req = SizeW'($urandom_range(1, (table_sb.pool > 0) ? table_sb.pool : 1));
          else if (pick < 90) req = '0;
          else req = SizeW'($urandom());
          a = AddrW'($urandom());
        end else begin
          pick = $urandom_range(0, 99);
          idx = $urandom_range(0, table_sb.blk_count - 1);
          for (int k = 0; k < table_sb.blk_count && pick < 80; k++) begin
            if (!table_sb.blk_free[(idx + k) % table_sb.blk_count]) begin
              idx = (idx + k) % table_sb.blk_count;
              break;
            end
          end
          a = (pick < 90) ? table_sb.blk_off[idx] : AddrW'($urandom());
          req = SizeW'($urandom());
        end
        send(kind, req, a);
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    table_sb.set_pool(SizeW'(PoolLimit));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero size, no fit, exact fit, bad frees and merges.
    send(ffba_pkg::KindAlloc, '0, '0);
    send(ffba_pkg::KindAlloc, 17'h1ffff, '0);
    send(ffba_pkg::KindAlloc, 17'h10000, 16'hffff);
    send(ffba_pkg::KindAlloc, 17'd1, '0);
    send(ffba_pkg::KindFree, '0, 16'h0000);
    send(ffba_pkg::KindFree, '0, 16'h0000);
    send(ffba_pkg::KindFree, 17'h1ffff, 16'hffff);
    send(ffba_pkg::KindAlloc, 17'd100, '0);
    send(ffba_pkg::KindAlloc, 17'd200, '0);
    send(ffba_pkg::KindAlloc, 17'd300, '0);
    send(ffba_pkg::KindFree, '0, 16'd100);
    send(ffba_pkg::KindFree, '0, 16'd100);
    send(ffba_pkg::KindFree, '0, 16'd0);
    send(ffba_pkg::KindFree, '0, 16'd300);
    send(ffba_pkg::KindAlloc, 17'd65236, '0);
    send(ffba_pkg::KindAlloc, 17'd300, '0);
    send(ffba_pkg::KindFree, '0, 16'd300);
    send(ffba_pkg::KindFree, '0, 16'd0);
    drain();
    random_items(200);

    write_pool('0);
    send(ffba_pkg::KindAlloc, 17'd4, '0);
    send(ffba_pkg::KindFree, '0, '0);
    random_items(10);

    write_pool(17'd1);
    send(ffba_pkg::KindAlloc, 17'd1, '0);
    send(ffba_pkg::KindAlloc, 17'd1, '0);
    send(ffba_pkg::KindFree, '0, '0);
    random_items(30);

    write_pool(17'd300);
    random_items(150);
    write_pool(17'h1ffff);
    random_items(300);
    write_pool(17'd4096);
    random_items(250);
    write_pool(17'h10000);
    random_items(150);

    if (table_sb.errors == 0 && table_sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
